// ===== rtl/outline_vertex_welder_defines.svh =====
// ----------------------------------------------------------------------------
// Outline vertex welder assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef OUTLINE_VERTEX_WELDER_DEFINES_SVH
`define OUTLINE_VERTEX_WELDER_DEFINES_SVH
`ifndef SYNTHESIS
`define OVW_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("ovw assertion failed");
`define OVW_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("ovw assertion failed");
`else
`define OVW_ASSERT(lbl, clk, rstn, prop)
`define OVW_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/ovw_pkg.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder package
// Command and result records shared by the front, back and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
package ovw_pkg;
	typedef enum logic [2:0] {
		FUNC_CLEAR = 3'd0,
		FUNC_MOVE  = 3'd1,
		FUNC_LINE  = 3'd2,
		FUNC_CONIC = 3'd3,
		FUNC_CUBIC = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		KIND_VERTEX     = 3'd0,
		KIND_START      = 3'd1,
		KIND_LINE       = 3'd2,
		KIND_CURVE      = 3'd3,
		KIND_CUBIC_ERR  = 3'd4,
		KIND_NO_CONTOUR = 3'd5,
		KIND_FULL       = 3'd6,
		KIND_CLEAR      = 3'd7
	} kind_t;

	typedef struct packed {
		func_t       op;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] tx;
		logic [15:0] ty;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  index_a;
		logic [7:0]  index_b;
		logic [7:0]  index_c;
		logic [15:0] vert_x;
		logic [15:0] vert_y;
		logic [15:0] contour_number;
		logic        last;
	} res_t;

	localparam res_t RES_ZERO = '{kind: KIND_VERTEX, default: '0};
endpackage
`default_nettype wire

// ===== rtl/ovw_front.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder front
// Accepts commands, drops unused codes and queues the rest for the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "outline_vertex_welder_defines.svh"
module ovw_front import ovw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  func,
	input  wire logic [15:0] ctrl_x,
	input  wire logic [15:0] ctrl_y,
	input  wire logic [15:0] to_x,
	input  wire logic [15:0] to_y,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_pop
);
	cmd_t       cq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       keep, wr, rd;

	always_comb begin
		unique case (func)
			FUNC_CLEAR, FUNC_MOVE, FUNC_LINE, FUNC_CONIC, FUNC_CUBIC: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign wr        = push & ~full & keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign rd        = cmd_pop & cmd_valid;
	assign cmd       = cq_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			cq_q[wp_q] <= '{op: func_t'(func), cx: ctrl_x, cy: ctrl_y, tx: to_x, ty: to_y};
		end
	end

	`OVW_ASSERT(a_front_no_underflow, clk, arst_n, cmd_pop |-> cmd_valid)
	`OVW_ASSERT_NR(a_front_cnt, clk, !arst_n || (cnt_q != 2'd3))
	`OVW_ASSERT(a_front_drop, clk, arst_n, (push && !full && !keep) |=> cnt_q == $past(cnt_q) - {1'b0, $past(rd)})
endmodule
`default_nettype wire

// ===== rtl/ovw_rq.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder result queue
// Four-entry queue that parts the back from the result consumer.
// ----------------------------------------------------------------------------
`default_nettype none
module ovw_rq import ovw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  res_t      wdata,
	output logic      rq_full,
	output logic      empty,
	input  wire logic pop,
	output res_t      rdata
);
	res_t       q_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       rd;

	assign rq_full = (cnt_q == 3'd4);
	assign empty   = (cnt_q == 3'd0);
	assign rd      = pop & ~empty;
	assign rdata   = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/ovw_back.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder back
// Searches the vertex table one entry a cycle, appends and emits records.
// ----------------------------------------------------------------------------
`default_nettype none
`include "outline_vertex_welder_defines.svh"
module ovw_back import ovw_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      rq_wr,
	output res_t      rq_data,
	input  wire logic rq_full
);
	localparam int CB = COORD_BITS;
	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW:0] MAXV = (CW + 1)'(MAX_VERTICES);

	typedef enum logic [2:0] {ST_IDLE, ST_SRCH, ST_DECIDE, ST_EMIT_C, ST_EMIT_T, ST_EMIT_F} state_t;

	function automatic logic [CB-1:0] sx(input logic [15:0] v);
		logic [31:0] w;
		w = {16'b0, v};
		return w[CB-1:0];
	endfunction

	function automatic logic [15:0] vout(input logic [CB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	function automatic logic within_one(input logic [CB:0] d);
		return (d == '0) || (d == (CB + 1)'(1)) || (d == '1);
	endfunction

	function automatic logic near_f(input logic [CB-1:0] ax, ay, bx, by);
		logic [CB:0] dx, dy;
		dx = {ax[CB-1], ax} - {bx[CB-1], bx};
		dy = {ay[CB-1], ay} - {by[CB-1], by};
		return ((dx == '0) && within_one(dy)) || ((dy == '0) && within_one(dx));
	endfunction

	state_t          state_q;
	func_t           op_q;
	logic            phase_q;
	logic [CB-1:0]   cx_q, cy_q, tx_q, ty_q;
	logic [CW-1:0]   cnt_q, rd_q;
	logic            pend_s1;
	logic [IW-1:0]   pidx_s1;
	logic [2*CB-1:0] rdata_s1;
	logic [2*CB-1:0] vmem_q [MAX_VERTICES];
	logic            found_c_q, found_t_q;
	logic [IW-1:0]   ic_q, it_q, prev_q, nprev_q;
	logic            open_q;
	logic [15:0]     total_q;
	logic            em_t_q;
	res_t            fin_q;

	logic [CB-1:0] ptx, pty;
	logic          hit, miss, mem_we;
	logic [2*CB-1:0] mem_wd;

	logic          cnew, enew, tnew, near_tc, full_c, full_t;
	logic [IW-1:0] ci, ei, idx_t;
	logic [CW-1:0] ei_w;
	logic [CW:0]   need;
	logic [15:0]   total_nx;

	assign ptx  = phase_q ? tx_q : cx_q;
	assign pty  = phase_q ? ty_q : cy_q;
	assign hit  = pend_s1 && near_f(rdata_s1[CB-1:0], rdata_s1[2*CB-1:CB], ptx, pty);
	assign miss = !pend_s1 && (rd_q == cnt_q);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		cnew     = !found_c_q;
		ci       = found_c_q ? ic_q : cnt_q[IW-1:0];
		near_tc  = near_f(tx_q, ty_q, cx_q, cy_q);
		ei_w     = cnt_q + CW'(cnew);
		if (found_t_q) begin
			ei   = it_q;
			enew = 1'b0;
		end else if (cnew && near_tc) begin
			ei   = ci;
			enew = 1'b0;
		end else begin
			ei   = ei_w[IW-1:0];
			enew = 1'b1;
		end
		need     = {1'b0, cnt_q} + (CW + 1)'(cnew) + (CW + 1)'(enew);
		full_c   = need > MAXV;
		tnew     = !found_t_q;
		idx_t    = found_t_q ? it_q : cnt_q[IW-1:0];
		full_t   = tnew && ({1'b0, cnt_q} == MAXV);
		total_nx = (total_q == 16'hFFFF) ? total_q : total_q + 16'd1;
	end

	always_comb begin
		rq_data = RES_ZERO;
		rq_wr   = 1'b0;
		mem_we  = 1'b0;
		mem_wd  = {ty_q, tx_q};
		case (state_q)
			ST_EMIT_C: begin
				rq_wr           = !rq_full;
				mem_we          = !rq_full;
				mem_wd          = {cy_q, cx_q};
				rq_data.index_a = 8'(cnt_q[IW-1:0]);
				rq_data.vert_x  = vout(cx_q);
				rq_data.vert_y  = vout(cy_q);
			end
			ST_EMIT_T: begin
				rq_wr           = !rq_full;
				mem_we          = !rq_full;
				rq_data.index_a = 8'(cnt_q[IW-1:0]);
				rq_data.vert_x  = vout(tx_q);
				rq_data.vert_y  = vout(ty_q);
			end
			ST_EMIT_F: begin
				rq_wr   = !rq_full;
				rq_data = fin_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem_q[cnt_q[IW-1:0]] <= mem_wd;
		end
		rdata_s1 <= vmem_q[rd_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= FUNC_CLEAR;
			phase_q   <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			tx_q      <= '0;
			ty_q      <= '0;
			cnt_q     <= '0;
			rd_q      <= '0;
			pend_s1   <= 1'b0;
			pidx_s1   <= '0;
			found_c_q <= 1'b0;
			found_t_q <= 1'b0;
			ic_q      <= '0;
			it_q      <= '0;
			prev_q    <= '0;
			nprev_q   <= '0;
			open_q    <= 1'b0;
			total_q   <= '0;
			em_t_q    <= 1'b0;
			fin_q     <= RES_ZERO;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						cx_q    <= sx(cmd.cx);
						cy_q    <= sx(cmd.cy);
						tx_q    <= sx(cmd.tx);
						ty_q    <= sx(cmd.ty);
						rd_q    <= '0;
						pend_s1 <= 1'b0;
						em_t_q  <= 1'b0;
						unique case (cmd.op)
							FUNC_CLEAR: begin
								fin_q   <= '{kind: KIND_CLEAR, last: 1'b1, default: '0};
								state_q <= ST_EMIT_F;
							end
							FUNC_MOVE: begin
								fin_q   <= '{kind: KIND_VERTEX, last: 1'b1, default: '0};
								phase_q <= 1'b1;
								state_q <= ST_SRCH;
							end
							FUNC_LINE, FUNC_CONIC: begin
								if (!open_q) begin
									fin_q   <= '{kind: KIND_NO_CONTOUR, last: 1'b1, default: '0};
									state_q <= ST_EMIT_F;
								end else begin
									fin_q   <= '{kind: KIND_VERTEX, last: 1'b1, default: '0};
									phase_q <= (cmd.op == FUNC_LINE);
									state_q <= ST_SRCH;
								end
							end
							default: begin
								fin_q   <= '{kind: KIND_CUBIC_ERR, last: 1'b1, default: '0};
								state_q <= ST_EMIT_F;
							end
						endcase
					end
				end
				ST_SRCH: begin
					if ((hit || miss) && !phase_q) begin
						found_c_q <= hit;
						ic_q      <= pidx_s1;
						phase_q   <= 1'b1;
						rd_q      <= '0;
						pend_s1   <= 1'b0;
					end else begin
						if (rd_q < cnt_q) begin
							rd_q    <= rd_q + CW'(1);
							pend_s1 <= 1'b1;
							pidx_s1 <= rd_q[IW-1:0];
						end else begin
							pend_s1 <= 1'b0;
						end
						if (hit || miss) begin
							found_t_q <= hit;
							it_q      <= pidx_s1;
							state_q   <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (op_q == FUNC_CONIC) begin
						if (full_c) begin
							fin_q.kind <= KIND_FULL;
							state_q    <= ST_EMIT_F;
						end else begin
							em_t_q        <= enew;
							nprev_q       <= ei;
							fin_q.kind    <= KIND_CURVE;
							fin_q.index_a <= 8'(prev_q);
							fin_q.index_b <= 8'(ci);
							fin_q.index_c <= 8'(ei);
							state_q       <= cnew ? ST_EMIT_C : (enew ? ST_EMIT_T : ST_EMIT_F);
						end
					end else if (full_t) begin
						fin_q.kind <= KIND_FULL;
						state_q    <= ST_EMIT_F;
					end else begin
						em_t_q  <= tnew;
						nprev_q <= idx_t;
						if (op_q == FUNC_MOVE) begin
							fin_q.kind           <= KIND_START;
							fin_q.index_a        <= 8'(idx_t);
							fin_q.contour_number <= total_nx;
						end else begin
							fin_q.kind    <= KIND_LINE;
							fin_q.index_a <= 8'(prev_q);
							fin_q.index_b <= 8'(idx_t);
						end
						state_q <= tnew ? ST_EMIT_T : ST_EMIT_F;
					end
				end
				ST_EMIT_C: begin
					if (!rq_full) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= em_t_q ? ST_EMIT_T : ST_EMIT_F;
					end
				end
				ST_EMIT_T: begin
					if (!rq_full) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_EMIT_F;
					end
				end
				ST_EMIT_F: begin
					if (!rq_full) begin
						state_q <= ST_IDLE;
						case (fin_q.kind)
							KIND_CLEAR: begin
								cnt_q   <= '0;
								prev_q  <= '0;
								open_q  <= 1'b0;
								total_q <= '0;
							end
							KIND_START: begin
								open_q  <= 1'b1;
								total_q <= fin_q.contour_number;
								prev_q  <= nprev_q;
							end
							KIND_LINE, KIND_CURVE: prev_q <= nprev_q;
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`OVW_ASSERT_NR(a_cnt_bound, clk, !arst_n || ({1'b0, cnt_q} <= MAXV))
	`OVW_ASSERT(a_no_write_full, clk, arst_n, rq_wr |-> !rq_full)
	`OVW_ASSERT(a_scan_bound, clk, arst_n, (state_q == ST_SRCH) |-> rd_q <= cnt_q)
	`OVW_ASSERT(a_last_on_final, clk, arst_n, (rq_wr && state_q != ST_EMIT_F) |-> !rq_data.last)
endmodule
`default_nettype wire

// ===== rtl/outline_vertex_welder.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder
// Builds an indexed outline mesh from glyph outline commands.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are worked one at a time. Each point
// is welded by scanning the vertex table one entry a cycle from index 0 up
// to the first match or the last stored vertex; a conic scans twice. Results
// wait in a four-entry queue; a full result queue stalls the back.
`default_nettype none
module outline_vertex_welder import ovw_pkg::*; #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  func,
	input  wire logic [15:0] ctrl_x,
	input  wire logic [15:0] ctrl_y,
	input  wire logic [15:0] to_x,
	input  wire logic [15:0] to_y,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [7:0]       index_a,
	output logic [7:0]       index_b,
	output logic [7:0]       index_c,
	output logic [15:0]      vert_x,
	output logic [15:0]      vert_y,
	output logic [15:0]      contour_number,
	output logic             last
);
	logic cmd_valid, cmd_pop, rq_wr, rq_full;
	cmd_t cmd;
	res_t rq_data, res;

	ovw_front u_front (
		.clk, .arst_n, .push, .full, .func, .ctrl_x, .ctrl_y, .to_x, .to_y,
		.cmd_valid, .cmd, .cmd_pop
	);

	ovw_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .rq_wr, .rq_data, .rq_full
	);

	ovw_rq u_rq (
		.clk, .arst_n, .wr(rq_wr), .wdata(rq_data), .rq_full, .empty, .pop,
		.rdata(res)
	);

	assign kind           = res.kind;
	assign index_a        = res.index_a;
	assign index_b        = res.index_b;
	assign index_c        = res.index_c;
	assign vert_x         = res.vert_x;
	assign vert_y         = res.vert_y;
	assign contour_number = res.contour_number;
	assign last           = res.last;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Outline vertex welder testbench
// Drives outline commands through the push/full queue, predicts the records
// each command causes with a local vertex-table model, and checks every
// popped record field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench import ovw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [2:0] func = '0;
	logic [15:0] ctrl_x = '0, ctrl_y = '0, to_x = '0, to_y = '0;
	logic empty;
	logic pop = 0;
	logic [2:0] kind;
	logic [7:0] index_a, index_b, index_c;
	logic [15:0] vert_x, vert_y, contour_number;
	logic last;

	outline_vertex_welder dut (.*);

	always #5 clk = ~clk;

	localparam int TABLE_DEPTH = 256;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;

	logic signed [15:0] table_x [TABLE_DEPTH];
	logic signed [15:0] table_y [TABLE_DEPTH];
	int unsigned vertex_total;
	logic [7:0] prev_idx;
	logic contour_live;
	logic [15:0] contour_count;

	res_t pending_records[$];
	int mismatches = 0;
	bit idle_on = 1;
	int hold_req = 0;
	int pop_wait = 0;

	function automatic bit near(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by);
		int dx, dy;
		dx = int'(ax) - int'(bx);
		dy = int'(ay) - int'(by);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return dx + dy <= 1;
	endfunction

	function automatic int weld_search(logic signed [15:0] x, logic signed [15:0] y);
		for (int i = 0; i < vertex_total; i++)
			if (near(x, y, table_x[i], table_y[i])) return i;
		return -1;
	endfunction

	function automatic void record(kind_t k, int a = 0, int b = 0, int c = 0,
			logic [15:0] x = '0, logic [15:0] y = '0, logic [15:0] cn = '0);
		res_t r;
		r = RES_ZERO;
		r.kind = k;
		r.index_a = a[7:0];
		r.index_b = b[7:0];
		r.index_c = c[7:0];
		r.vert_x = x;
		r.vert_y = y;
		r.contour_number = cn;
		pending_records.push_back(r);
	endfunction

	function automatic void add_vertex(logic signed [15:0] x, logic signed [15:0] y);
		table_x[vertex_total] = x;
		table_y[vertex_total] = y;
		vertex_total++;
	endfunction

	function automatic void weld_command(logic [2:0] op, logic signed [15:0] cx,
			logic signed [15:0] cy, logic signed [15:0] tx, logic signed [15:0] ty);
		int start_size, ti, cf, ef, ci, ei, need;
		bit cnew, enew;
		start_size = pending_records.size();
		case (op)
			FUNC_CLEAR: begin
				vertex_total = 0;
				prev_idx = 0;
				contour_live = 0;
				contour_count = 0;
				record(KIND_CLEAR);
			end
			FUNC_MOVE: begin
				ti = weld_search(tx, ty);
				if (ti < 0 && vertex_total + 1 > TABLE_DEPTH) begin
					record(KIND_FULL);
				end else begin
					if (ti < 0) begin
						ti = vertex_total;
						add_vertex(tx, ty);
						record(KIND_VERTEX, ti, 0, 0, tx, ty);
					end
					if (contour_count != 16'hFFFF) contour_count++;
					contour_live = 1;
					prev_idx = ti[7:0];
					record(KIND_START, ti, 0, 0, '0, '0, contour_count);
				end
			end
			FUNC_LINE, FUNC_CONIC: begin
				if (!contour_live) begin
					record(KIND_NO_CONTOUR);
				end else if (op == FUNC_LINE) begin
					ti = weld_search(tx, ty);
					if (ti < 0 && vertex_total + 1 > TABLE_DEPTH) begin
						record(KIND_FULL);
					end else begin
						if (ti < 0) begin
							ti = vertex_total;
							add_vertex(tx, ty);
							record(KIND_VERTEX, ti, 0, 0, tx, ty);
						end
						record(KIND_LINE, prev_idx, ti);
						prev_idx = ti[7:0];
					end
				end else begin
					need = 0;
					cnew = 0;
					enew = 0;
					cf = weld_search(cx, cy);
					ef = weld_search(tx, ty);
					if (cf < 0) begin
						ci = vertex_total;
						cnew = 1;
						need++;
					end else ci = cf;
					if (ef >= 0) ei = ef;
					else if (cnew && near(tx, ty, cx, cy)) ei = ci;
					else begin
						ei = vertex_total + need;
						enew = 1;
						need++;
					end
					if (vertex_total + need > TABLE_DEPTH) begin
						record(KIND_FULL);
					end else begin
						if (cnew) begin
							add_vertex(cx, cy);
							record(KIND_VERTEX, ci, 0, 0, cx, cy);
						end
						if (enew) begin
							add_vertex(tx, ty);
							record(KIND_VERTEX, ei, 0, 0, tx, ty);
						end
						record(KIND_CURVE, prev_idx, ci, ei);
						prev_idx = ei[7:0];
					end
				end
			end
			FUNC_CUBIC: record(KIND_CUBIC_ERR);
			default: ;
		endcase
		if (pending_records.size() > start_size) pending_records[$].last = 1'b1;
	endfunction

	task automatic send(logic [2:0] op, logic [15:0] cx, logic [15:0] cy,
			logic [15:0] tx, logic [15:0] ty);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		repeat (gap) begin
			@(negedge clk);
			push = 0;
		end
		@(negedge clk);
		push = 1;
		func = op;
		ctrl_x = cx;
		ctrl_y = cy;
		to_x = tx;
		to_y = ty;
		do @(posedge clk); while (full);
		weld_command(op, cx, cy, tx, ty);
	endtask

	task automatic drain();
		@(negedge clk);
		push = 0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		res_t got;
		if (arst_n && pop && !empty) begin
			got = {kind_t'(kind), index_a, index_b, index_c, vert_x, vert_y,
				contour_number, last};
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat: %p", got);
			end else begin
				if (got !== pending_records[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: expected %p actual %p",
							pending_records[0], got);
				end
				void'(pending_records.pop_front());
			end
			pop_wait = idle_on ? $urandom_range(0, 9) : 0;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_req--;
				pop = 0;
			end else if (pop_wait > 0) begin
				pop_wait--;
				pop = 0;
			end else pop = 1;
		end
	end

	function automatic logic [15:0] pick_coord();
		if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 12)) - 16'd6;
		return 16'($urandom());
	endfunction

	task automatic test_errors();
		send(FUNC_LINE, 0, 0, 5, 5);
		send(FUNC_CONIC, 1, 1, 2, 2);
		send(FUNC_CUBIC, 16'h7FFF, 16'h8000, 16'hFFFF, 0);
		send(3'd5, 0, 0, 0, 0);
		send(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(3'd7, 0, 0, 0, 0);
		send(FUNC_CLEAR, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_shapes();
		send(FUNC_MOVE, 0, 0, 0, 0);
		send(FUNC_MOVE, 0, 0, 1, 0);
		send(FUNC_LINE, 0, 0, 16'h7FFF, 16'h8000);
		send(FUNC_LINE, 0, 0, 0, 1);
		send(FUNC_LINE, 0, 0, 1, 1);
		send(FUNC_CONIC, 100, 100, 101, 100);
		send(FUNC_CONIC, 0, 0, 100, 100);
		send(FUNC_CONIC, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		send(FUNC_CONIC, 50, 50, 53, 50);
		send(FUNC_CUBIC, 1, 2, 3, 4);
		send(FUNC_MOVE, 0, 0, 16'hFFFF, 16'hFFFF);
		send(FUNC_LINE, 0, 0, 16'h8000, 16'h8000);
		send(FUNC_CLEAR, 0, 0, 0, 0);
		send(FUNC_LINE, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_table_full();
		idle_on = 0;
		send(FUNC_CLEAR, 0, 0, 0, 0);
		send(FUNC_MOVE, 0, 0, 0, 0);
		for (int i = 1; i < TABLE_DEPTH - 1; i++)
			send(FUNC_LINE, 0, 0, 16'(i * 3), 16'(i * 5));
		send(FUNC_CONIC, 16'h4000, 0, 16'h5000, 0);
		send(FUNC_CONIC, 3, 5, 16'h5000, 0);
		send(FUNC_LINE, 0, 0, 16'h6000, 0);
		send(FUNC_MOVE, 0, 0, 16'h6000, 0);
		send(FUNC_CONIC, 0, 0, 16'h6000, 0);
		send(FUNC_MOVE, 0, 0, 3, 6);
		idle_on = 1;
		drain();
	endtask

	task automatic test_contour_count();
		idle_on = 0;
		send(FUNC_CLEAR, 0, 0, 0, 0);
		repeat (8) send(FUNC_MOVE, 0, 0, 0, 0);
		idle_on = 1;
		drain();
	endtask

	task automatic test_random();
		int sent, draws, pick;
		sent = 0;
		for (int g = 0; sent < 170; g++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (g == 6) hold_req = 300;
			send(FUNC_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord());
			if ($urandom_range(0, 5) != 0)
				send(FUNC_MOVE, pick_coord(), pick_coord(), pick_coord(), pick_coord());
			draws = $urandom_range(3, 15);
			sent += draws + 2;
			repeat (draws) begin
				pick = $urandom_range(0, 19);
				if (pick < 9)
					send(FUNC_LINE, pick_coord(), pick_coord(), pick_coord(),
						pick_coord());
				else if (pick < 17)
					send(FUNC_CONIC, pick_coord(), pick_coord(), pick_coord(),
						pick_coord());
				else if (pick == 17)
					send(FUNC_MOVE, pick_coord(), pick_coord(), pick_coord(),
						pick_coord());
				else
					send(3'($urandom_range(4, 7)), pick_coord(), pick_coord(),
						pick_coord(), pick_coord());
			end
			if (g == 4) drain();
		end
		idle_on = 1;
		drain();
	endtask

	initial begin
		vertex_total = 0;
		prev_idx = 0;
		contour_live = 0;
		contour_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_errors();
		test_shapes();
		test_table_full();
		test_contour_count();
		test_random();
		if (mismatches == 0 && pending_records.size() == 0)
			$display("outline_vertex_welder: match");
		else
			$display("outline_vertex_welder: mismatch");
		$finish;
	end

	initial begin
		#50ms;
		$display("outline_vertex_welder: mismatch");
		$finish;
	end
endmodule
